FILE: sv/wfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed FFT magnitude package
// Sizes, controller states, datapath command bundle and the constant
// table generators for the window and twiddle ROMs.
// ----------------------------------------------------------------------------
package wfm_pkg;

   // Frame and field sizes.
   localparam int FRAME_POINTS  = 1024;
   localparam int SAMPLE_BITS   = 12;
   localparam int LOG_N         = $clog2(FRAME_POINTS);
   localparam int STAGE_BITS    = $clog2(LOG_N);
   localparam int WORK_BITS     = 24;
   localparam int MAG_BITS      = 24;
   localparam int ROM_BITS      = 17;
   localparam int TW_BITS       = 17;
   localparam int ROOT_STEPS    = WORK_BITS;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);

   // Fixed-point constants for the table generators.
   localparam longint unsigned ONE_Q31    = 64'd2147483648;
   localparam longint unsigned PI4_Q31    = 64'd1686629713;
   localparam longint          ROM_DIV    = 64'sd3276800000;
   localparam longint unsigned WIN_PERIOD = FRAME_POINTS - 1;
   localparam longint unsigned TW_PERIOD  = FRAME_POINTS;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN_RD,
      ST_WIN_MUL,
      ST_WIN_WR,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WRP,
      ST_BF_WRQ,
      ST_MG_RD,
      ST_MG_SQ,
      ST_MG_SUM,
      ST_MG_ROOT,
      ST_MG_WR
   } state_type;

   // Source of the work memory write data.
   typedef enum logic [1:0] {
      WSEL_WIN,
      WSEL_P,
      WSEL_Q
   } wsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   cap_we;
      logic [LOG_N-1:0]       cap_addr;
      logic                   win_rd;
      logic                   win_mul;
      logic                   work_rd;
      logic [LOG_N-1:0]       addr_p;
      logic [LOG_N-1:0]       addr_q;
      logic                   tw_rd;
      logic [LOG_N-2:0]       tw_addr;
      logic                   bf_mul;
      logic                   bf_sum;
      logic                   work_we;
      wsel_type               wsel;
      logic [LOG_N-1:0]       work_waddr;
      logic                   mg_sq;
      logic                   root_init;
      logic                   root_step;
      logic                   mag_rd;
      logic                   mag_we;
      logic [LOG_N-1:0]       mag_addr;
   } cmd_type;

   typedef logic [ROM_BITS-1:0]       win_rom_type [FRAME_POINTS];
   typedef logic signed [TW_BITS-1:0] tw_rom_type  [FRAME_POINTS/2];

   function automatic logic [LOG_N-1:0] bit_reverse(input logic [LOG_N-1:0] v);
      logic [LOG_N-1:0] r;
      for (int b = 0; b < LOG_N; b++) begin
         r[LOG_N-1-b] = v[b];
      end
      return r;
   endfunction

   function automatic longint unsigned mul_q31(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b) >> 31;
   endfunction

   // Taylor series of the cosine in Q31 for a small angle.
   function automatic longint unsigned cos_small(input longint unsigned x);
      longint unsigned x2, term, sum;
      x2   = mul_q31(x, x);
      term = ONE_Q31;
      sum  = ONE_Q31;
      term = mul_q31(term, x2) / 2;   sum = sum - term;
      term = mul_q31(term, x2) / 12;  sum = sum + term;
      term = mul_q31(term, x2) / 30;  sum = sum - term;
      term = mul_q31(term, x2) / 56;  sum = sum + term;
      term = mul_q31(term, x2) / 90;  sum = sum - term;
      term = mul_q31(term, x2) / 132; sum = sum + term;
      term = mul_q31(term, x2) / 182; sum = sum - term;
      term = mul_q31(term, x2) / 240; sum = sum + term;
      term = mul_q31(term, x2) / 306; sum = sum - term;
      term = mul_q31(term, x2) / 380; sum = sum + term;
      return sum;
   endfunction

   // Taylor series of the sine in Q31 for a small angle.
   function automatic longint unsigned sin_small(input longint unsigned x);
      longint unsigned x2, term, sum;
      x2   = mul_q31(x, x);
      term = x;
      sum  = x;
      term = mul_q31(term, x2) / 6;   sum = sum - term;
      term = mul_q31(term, x2) / 20;  sum = sum + term;
      term = mul_q31(term, x2) / 42;  sum = sum - term;
      term = mul_q31(term, x2) / 72;  sum = sum + term;
      term = mul_q31(term, x2) / 110; sum = sum - term;
      term = mul_q31(term, x2) / 156; sum = sum + term;
      term = mul_q31(term, x2) / 210; sum = sum - term;
      term = mul_q31(term, x2) / 272; sum = sum + term;
      term = mul_q31(term, x2) / 342; sum = sum - term;
      term = mul_q31(term, x2) / 420; sum = sum + term;
      return sum;
   endfunction

   // Cosine of 2*pi*m/p in Q31, where p is the frame size when full is
   // set and the window period otherwise.
   function automatic longint cos_frac(input longint unsigned m, input logic full);
      longint unsigned p, mm, t, o, r, a, b;
      longint res;
      p = full ? TW_PERIOD : WIN_PERIOD;
      if (full) begin
         mm = m % TW_PERIOD;
         t  = 8 * mm;
         o  = t / TW_PERIOD;
         r  = t - o * p;
         a  = (PI4_Q31 * r + TW_PERIOD / 2) / TW_PERIOD;
         b  = (PI4_Q31 * (p - r) + TW_PERIOD / 2) / TW_PERIOD;
      end else begin
         mm = m % WIN_PERIOD;
         t  = 8 * mm;
         o  = t / WIN_PERIOD;
         r  = t - o * p;
         a  = (PI4_Q31 * r + WIN_PERIOD / 2) / WIN_PERIOD;
         b  = (PI4_Q31 * (p - r) + WIN_PERIOD / 2) / WIN_PERIOD;
      end
      case (o[2:0])
         3'd0:    res = longint'(cos_small(a));
         3'd1:    res = longint'(sin_small(b));
         3'd2:    res = -longint'(sin_small(a));
         3'd3:    res = -longint'(cos_small(b));
         3'd4:    res = -longint'(cos_small(a));
         3'd5:    res = -longint'(sin_small(b));
         3'd6:    res = longint'(sin_small(a));
         default: res = longint'(cos_small(b));
      endcase
      return res;
   endfunction

   function automatic longint round_q15(input longint c);
      return (c + 64'sd32768) >>> 16;
   endfunction

   // Four-term Blackman-Harris window, unsigned Q1.16 rounded to nearest.
   function automatic win_rom_type win_table();
      win_rom_type tbl;
      longint c1, c2, c3, s, v;
      for (int n = 0; n < FRAME_POINTS; n++) begin
         c1 = cos_frac(longint'(n), 1'b0);
         c2 = cos_frac(longint'(2 * n), 1'b0);
         c3 = cos_frac(longint'(3 * n), 1'b0);
         s  = 64'sd35875 * longint'(ONE_Q31) - 64'sd48829 * c1
              + 64'sd14128 * c2 - 64'sd1168 * c3;
         if (s < 0) begin
            s = 0;
         end
         v      = (s + ROM_DIV / 2) / ROM_DIV;
         tbl[n] = ROM_BITS'(v);
      end
      return tbl;
   endfunction

   // Real part of the twiddle factors in Q1.15.
   function automatic tw_rom_type tw_re_table();
      tw_rom_type tbl;
      for (int n = 0; n < FRAME_POINTS / 2; n++) begin
         tbl[n] = TW_BITS'(round_q15(cos_frac(longint'(n), 1'b1)));
      end
      return tbl;
   endfunction

   // Imaginary part of the twiddle factors in Q1.15.
   function automatic tw_rom_type tw_im_table();
      tw_rom_type tbl;
      for (int n = 0; n < FRAME_POINTS / 2; n++) begin
         tbl[n] = TW_BITS'(-round_q15(cos_frac(longint'(n + 3 * (FRAME_POINTS / 4)), 1'b1)));
      end
      return tbl;
   endfunction

endpackage
`default_nettype wire

FILE: sv/wfm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed FFT magnitude datapath
// Capture buffer, window and twiddle ROMs, complex work memory, butterfly
// multipliers, bit-serial square root and the magnitude store.
// ----------------------------------------------------------------------------
module wfm_datapath import wfm_pkg::*; (
   input  logic                          clock,
   input  cmd_type                       cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic [MAG_BITS-1:0]           magnitude
);

   localparam int WP_BITS   = SAMPLE_BITS + ROM_BITS + 1;
   localparam int PROD_BITS = WORK_BITS + TW_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int TR_BITS   = SUM_BITS - 15;
   localparam int RAD_BITS  = 2 * WORK_BITS;
   localparam int REM_BITS  = WORK_BITS + 2;

   localparam win_rom_type WIN_ROM = win_table();
   localparam tw_rom_type  TW_RE   = tw_re_table();
   localparam tw_rom_type  TW_IM   = tw_im_table();

   logic signed [SAMPLE_BITS-1:0] cap_mem [FRAME_POINTS];
   logic signed [WORK_BITS-1:0]   re_mem  [FRAME_POINTS];
   logic signed [WORK_BITS-1:0]   im_mem  [FRAME_POINTS];
   logic [MAG_BITS-1:0]           mag_mem [FRAME_POINTS];

   logic signed [SAMPLE_BITS-1:0] cap_rd_ff;
   logic [ROM_BITS-1:0]           rom_ff;
   logic signed [WP_BITS-1:0]     win_prod_ff, win_prod_in;
   logic signed [WORK_BITS-1:0]   a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [TW_BITS-1:0]     tw_re_ff, tw_im_ff;
   logic signed [PROD_BITS-1:0]   m_rr_ff, m_ii_ff, m_ri_ff, m_ir_ff;
   logic signed [SUM_BITS-1:0]    d_re, d_im;
   logic signed [TR_BITS-1:0]     tr_re_ff, tr_im_ff;
   logic signed [RAD_BITS-1:0]    sq_re_ff, sq_im_ff;
   logic [RAD_BITS-1:0]           rad_ff, rad_in;
   logic [REM_BITS-1:0]           rem_ff, rem_in;
   logic [WORK_BITS-1:0]          root_ff, root_in;
   logic [REM_BITS+1:0]           rem_sh, trial;
   logic signed [WORK_BITS-1:0]   wr_re, wr_im;
   logic [MAG_BITS-1:0]           mag_rd_ff;

   // Capture buffer: written by accepted beats, read by the window pass.
   always_ff @(posedge clock) begin
      if (cmd.cap_we) begin
         cap_mem[cmd.cap_addr] <= sample;
      end
      if (cmd.win_rd) begin
         cap_rd_ff <= cap_mem[cmd.cap_addr];
         rom_ff    <= WIN_ROM[cmd.cap_addr];
      end
   end

   // Windowed sample, floored by the shift right by 16.
   assign win_prod_in = cap_rd_ff * $signed({1'b0, rom_ff});

   always_ff @(posedge clock) begin
      if (cmd.win_mul) begin
         win_prod_ff <= win_prod_in;
      end
   end

   // Butterfly products and twiddled term.
   assign d_re = SUM_BITS'(m_rr_ff) - SUM_BITS'(m_ii_ff);
   assign d_im = SUM_BITS'(m_ri_ff) + SUM_BITS'(m_ir_ff);

   always_ff @(posedge clock) begin
      if (cmd.tw_rd) begin
         tw_re_ff <= TW_RE[cmd.tw_addr];
         tw_im_ff <= TW_IM[cmd.tw_addr];
      end
      if (cmd.bf_mul) begin
         m_rr_ff <= tw_re_ff * b_re_ff;
         m_ii_ff <= tw_im_ff * b_im_ff;
         m_ri_ff <= tw_re_ff * b_im_ff;
         m_ir_ff <= tw_im_ff * b_re_ff;
      end
      if (cmd.bf_sum) begin
         tr_re_ff <= TR_BITS'(d_re >>> 15);
         tr_im_ff <= TR_BITS'(d_im >>> 15);
      end
   end

   // Write data for the work memory; sums wrap to the work width.
   always_comb begin
      case (cmd.wsel)
         WSEL_WIN: begin
            wr_re = WORK_BITS'(win_prod_ff >>> 16);
            wr_im = '0;
         end
         WSEL_P: begin
            wr_re = WORK_BITS'(TR_BITS'(a_re_ff) + tr_re_ff);
            wr_im = WORK_BITS'(TR_BITS'(a_im_ff) + tr_im_ff);
         end
         WSEL_Q: begin
            wr_re = WORK_BITS'(TR_BITS'(a_re_ff) - tr_re_ff);
            wr_im = WORK_BITS'(TR_BITS'(a_im_ff) - tr_im_ff);
         end
         default: begin
            wr_re = '0;
            wr_im = '0;
         end
      endcase
   end

   // Work memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.work_we) begin
         re_mem[cmd.work_waddr] <= wr_re;
         im_mem[cmd.work_waddr] <= wr_im;
      end
      if (cmd.work_rd) begin
         a_re_ff <= re_mem[cmd.addr_p];
         a_im_ff <= im_mem[cmd.addr_p];
         b_re_ff <= re_mem[cmd.addr_q];
         b_im_ff <= im_mem[cmd.addr_q];
      end
   end

   // Squares of the bin's real and imaginary parts.
   always_ff @(posedge clock) begin
      if (cmd.mg_sq) begin
         sq_re_ff <= a_re_ff * a_re_ff;
         sq_im_ff <= a_im_ff * a_im_ff;
      end
   end

   // Restoring square root, one result bit per step.
   assign rem_sh = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.root_init) begin
         rad_in  = $unsigned(sq_re_ff) + $unsigned(sq_im_ff);
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_BITS'(rem_sh - trial);
            root_in = {root_ff[WORK_BITS-2:0], 1'b1};
         end else begin
            rem_in  = REM_BITS'(rem_sh);
            root_in = {root_ff[WORK_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // Magnitude store: written by the magnitude pass, read per accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.mag_we) begin
         mag_mem[cmd.mag_addr] <= MAG_BITS'(root_ff);
      end
      if (cmd.mag_rd) begin
         mag_rd_ff <= mag_mem[cmd.mag_addr];
      end
   end

   assign magnitude = mag_rd_ff;

endmodule
`default_nettype wire

FILE: sv/wfm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed FFT magnitude controller
// Tracks the frame position, sequences the window, butterfly and magnitude
// passes, and produces the result strobe with its bin number.
// ----------------------------------------------------------------------------
module wfm_ctrl import wfm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output cmd_type          cmd,
   output logic             rsp_strobe,
   output logic [LOG_N-1:0] rsp_bin_index,
   output logic             rsp_last_bin
);

   state_type              state_ff, state_in;
   logic [LOG_N-1:0]       pos_ff, pos_in;
   logic [LOG_N-1:0]       idx_ff, idx_in;
   logic [LOG_N-2:0]       bfly_ff, bfly_in;
   logic [STAGE_BITS-1:0]  stage_ff, stage_in;
   logic [ROOT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                   ready_ff, ready_in;
   logic                   strobe_ff;
   logic [LOG_N-1:0]       bin_ff;
   logic                   last_ff;
   logic                   accept;
   logic                   idx_last, bfly_last, stage_last, cnt_last;
   logic [LOG_N-1:0]       bfly_ext, half_mask, half_bit, addr_p, addr_q;
   logic [STAGE_BITS-1:0]  tw_shift;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign idx_last   = (idx_ff == '1);
   assign bfly_last  = (bfly_ff == '1);
   assign stage_last = (stage_ff == STAGE_BITS'(LOG_N - 1));
   assign cnt_last   = (cnt_ff == ROOT_CNT_BITS'(ROOT_STEPS - 1));

   // Butterfly addresses: insert a zero at the stage bit for the top leg.
   assign bfly_ext  = {1'b0, bfly_ff};
   assign half_bit  = LOG_N'(1) << stage_ff;
   assign half_mask = half_bit - LOG_N'(1);
   assign addr_p    = ((bfly_ext >> stage_ff) << (stage_ff + STAGE_BITS'(1)))
                      | (bfly_ext & half_mask);
   assign addr_q    = addr_p | half_bit;
   assign tw_shift  = STAGE_BITS'(LOG_N - 1) - stage_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && pos_ff == '1) state_in = ST_WIN_RD;
         ST_WIN_RD:  state_in = ST_WIN_MUL;
         ST_WIN_MUL: state_in = ST_WIN_WR;
         ST_WIN_WR:  state_in = idx_last ? ST_BF_RD : ST_WIN_RD;
         ST_BF_RD:   state_in = ST_BF_MUL;
         ST_BF_MUL:  state_in = ST_BF_SUM;
         ST_BF_SUM:  state_in = ST_BF_WRP;
         ST_BF_WRP:  state_in = ST_BF_WRQ;
         ST_BF_WRQ:  state_in = (bfly_last && stage_last) ? ST_MG_RD : ST_BF_RD;
         ST_MG_RD:   state_in = ST_MG_SQ;
         ST_MG_SQ:   state_in = ST_MG_SUM;
         ST_MG_SUM:  state_in = ST_MG_ROOT;
         ST_MG_ROOT: state_in = cnt_last ? ST_MG_WR : ST_MG_ROOT;
         ST_MG_WR:   state_in = idx_last ? ST_IDLE : ST_MG_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Counters and the spectrum-ready flag.
   always_comb begin
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      bfly_in  = bfly_ff;
      stage_in = stage_ff;
      cnt_in   = cnt_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = pos_ff + LOG_N'(1);
            end
            idx_in   = '0;
            bfly_in  = '0;
            stage_in = '0;
         end
         ST_WIN_WR: idx_in = idx_ff + LOG_N'(1);
         ST_BF_WRQ: begin
            bfly_in = bfly_ff + (LOG_N-1)'(1);
            if (bfly_last) begin
               stage_in = stage_ff + STAGE_BITS'(1);
            end
         end
         ST_MG_SUM: cnt_in = '0;
         ST_MG_ROOT: cnt_in = cnt_ff + ROOT_CNT_BITS'(1);
         ST_MG_WR: begin
            idx_in = idx_ff + LOG_N'(1);
            if (idx_last) begin
               ready_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd            = '0;
      cmd.wsel       = WSEL_WIN;
      cmd.addr_p     = addr_p;
      cmd.addr_q     = addr_q;
      cmd.tw_addr    = (LOG_N-1)'(bfly_ext & half_mask) << tw_shift;
      cmd.work_waddr = addr_p;
      cmd.cap_addr   = idx_ff;
      cmd.mag_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.cap_we   = accept;
            cmd.cap_addr = pos_ff;
            cmd.mag_rd   = accept && ready_ff;
            cmd.mag_addr = pos_ff;
         end
         ST_WIN_RD:  cmd.win_rd = 1'b1;
         ST_WIN_MUL: cmd.win_mul = 1'b1;
         ST_WIN_WR: begin
            cmd.work_we    = 1'b1;
            cmd.wsel       = WSEL_WIN;
            cmd.work_waddr = bit_reverse(idx_ff);
         end
         ST_BF_RD: begin
            cmd.work_rd = 1'b1;
            cmd.tw_rd   = 1'b1;
         end
         ST_BF_MUL: cmd.bf_mul = 1'b1;
         ST_BF_SUM: cmd.bf_sum = 1'b1;
         ST_BF_WRP: begin
            cmd.work_we    = 1'b1;
            cmd.wsel       = WSEL_P;
            cmd.work_waddr = addr_p;
         end
         ST_BF_WRQ: begin
            cmd.work_we    = 1'b1;
            cmd.wsel       = WSEL_Q;
            cmd.work_waddr = addr_q;
         end
         ST_MG_RD: begin
            cmd.work_rd = 1'b1;
            cmd.addr_p  = idx_ff;
         end
         ST_MG_SQ:   cmd.mg_sq = 1'b1;
         ST_MG_SUM:  cmd.root_init = 1'b1;
         ST_MG_ROOT: cmd.root_step = 1'b1;
         ST_MG_WR:   cmd.mag_we = 1'b1;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         idx_ff    <= '0;
         bfly_ff   <= '0;
         stage_ff  <= '0;
         cnt_ff    <= '0;
         ready_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         idx_ff    <= idx_in;
         bfly_ff   <= bfly_in;
         stage_ff  <= stage_in;
         cnt_ff    <= cnt_in;
         ready_ff  <= ready_in;
         strobe_ff <= accept && ready_ff;
      end
   end

   // Result tags, aligned with the registered magnitude read.
   always_ff @(posedge clock) begin
      if (accept) begin
         bin_ff  <= pos_ff;
         last_ff <= (pos_ff == '1);
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_bin_index = bin_ff;
   assign rsp_last_bin  = strobe_ff && last_ff;

   // A result only follows an accepted beat once a spectrum exists.
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(start && state_ff == ST_IDLE && ready_ff))
      else $error("result strobe without a preceding accepted beat");

   // The final beat of a frame starts the window pass.
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff == '1) |=> (state_ff == ST_WIN_RD))
      else $error("frame end did not start the transform");

   // A finished magnitude pass leaves the position at the frame start.
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MG_WR && idx_last) |=> (pos_ff == '0 && ready_ff))
      else $error("frame position not at start after transform");

   // The last bin flag only comes with the top bin number.
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_last_bin |-> (strobe_ff && bin_ff == '1))
      else $error("last bin flag on a bin that is not the last");

endmodule
`default_nettype wire

FILE: sv/windowed_fft_magnitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed FFT magnitude
// Collects frames of samples, applies a Blackman-Harris window, runs a
// radix-2 FFT and returns the previous frame's bin magnitudes per sample.
//
//   Channel   Ports                                     Handshake
//   request   req_sample                                start high, busy low
//   result    rsp_bin_index, rsp_magnitude, rsp_last_bin  rsp_strobe, 1 cycle
//
// A sample is taken while busy is low; its result appears on the next cycle.
// The last sample of a frame raises busy for the transform: a window pass
// (read, multiply, write) over all N samples, (N/2)*log2(N) butterflies
// (read, multiply, sum, write P, write Q) on the shared unit, and a
// magnitude pass per bin through the one-bit-per-cycle square root.
// Reset clears the frame position; the first frame returns no results.
// The receiver cannot stall: each result beat is valid for one cycle.
// ----------------------------------------------------------------------------
module windowed_fft_magnitude import wfm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_strobe,
   output logic [LOG_N-1:0]              rsp_bin_index,
   output logic [MAG_BITS-1:0]           rsp_magnitude,
   output logic                          rsp_last_bin
);

   cmd_type cmd;

   // Sequencer.
   wfm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .cmd           (cmd),
      .rsp_strobe    (rsp_strobe),
      .rsp_bin_index (rsp_bin_index),
      .rsp_last_bin  (rsp_last_bin)
   );

   // Storage and arithmetic.
   wfm_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .sample    (req_sample),
      .magnitude (rsp_magnitude)
   );

endmodule
`default_nettype wire
